// ----- hw/rtl/b64sc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64sc_pkg
// shared types, constants and character mapping functions of the base64 codec
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'd61;  // '='
    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // group being gathered
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
        logic [1:0]  pad;
    } t_group;

    // up to four result words made by one item
    typedef struct packed {
        logic [3:0][7:0] bytes;     // word 0 in bytes[0]
        logic [1:0]      last_idx;  // index of the final word
        logic            last;
        logic            bad;
    } t_result;

    // alphabet character of a sextet
    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;       // 'a' - 26
        end else if (v < 6'd62) begin
            return w - 8'd4;        // '0' - 52
        end else if (v == 6'd62) begin
            return 8'd43;           // '+'
        end else begin
            return 8'd47;           // '/'
        end
    endfunction

    // sextet of a character, SEXTET_PAD for '=', SEXTET_BAD otherwise
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        if (ch >= 8'd65 && ch <= 8'd90) begin
            return 7'(ch - 8'd65);
        end else if (ch >= 8'd97 && ch <= 8'd122) begin
            return 7'(ch - 8'd71);
        end else if (ch >= 8'd48 && ch <= 8'd57) begin
            return 7'(ch + 8'd4);
        end else if (ch == 8'd43) begin
            return 7'd62;
        end else if (ch == 8'd47) begin
            return 7'd63;
        end else if (ch == PAD_CHAR) begin
            return SEXTET_PAD;
        end else begin
            return SEXTET_BAD;
        end
    endfunction

endpackage

// ----- hw/rtl/b64sc_in_if.sv -----
// ----------------------------------------------------------------------------
// b64sc_in_if
// input word channel of the base64 codec: valid/ready with byte and last flag
// ----------------------------------------------------------------------------
interface b64sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- hw/rtl/b64sc_out_if.sv -----
// ----------------------------------------------------------------------------
// b64sc_out_if
// result word channel of the base64 codec: valid/ready with byte and flags
// ----------------------------------------------------------------------------
interface b64sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_input;

    modport source (output valid, output out_byte, output out_last, output bad_input,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input bad_input,
                    output ready);
endinterface

// ----- hw/rtl/b64sc_group_logic.sv -----
// ----------------------------------------------------------------------------
// b64sc_group_logic
// folds one word into the current group and builds the result words
// ----------------------------------------------------------------------------
module b64sc_group_logic (
    input  b64sc_pkg::t_group  i_group,
    input  logic               i_mode,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output b64sc_pkg::t_group  o_group,
    output logic               o_emit,
    output b64sc_pkg::t_result o_res
);

    logic [23:0] enc_bits;
    logic [2:0]  enc_cnt;
    logic [6:0]  sext;
    logic        is_pad;
    logic        dec_bad;
    logic [23:0] dec_bits;
    logic [1:0]  dec_pad;

    always_comb begin
        // encode: byte lands at its place in the group
        enc_bits = i_group.bits;
        unique case (i_group.count)
            2'd0:    enc_bits[23:16] = i_byte;
            2'd1:    enc_bits[15:8]  = i_byte;
            default: enc_bits[7:0]   = i_byte;
        endcase
        enc_cnt = {1'b0, i_group.count} + 3'd1;

        // decode: classify and place the sextet
        sext    = b64sc_pkg::sextet_of(i_byte);
        is_pad  = (sext == b64sc_pkg::SEXTET_PAD);
        dec_bad = (sext == b64sc_pkg::SEXTET_BAD)
               || (is_pad && i_group.count < 2'd2)
               || (!is_pad && i_group.pad != 2'd0);
        dec_bits = i_group.bits;
        dec_pad  = i_group.pad;
        if (is_pad) begin
            dec_pad = i_group.pad + 2'd1;
        end else begin
            unique case (i_group.count)
                2'd0:    dec_bits[23:18] = sext[5:0];
                2'd1:    dec_bits[17:12] = sext[5:0];
                2'd2:    dec_bits[11:6]  = sext[5:0];
                default: dec_bits[5:0]   = sext[5:0];
            endcase
        end

        o_group  = '0;
        o_emit   = 1'b0;
        o_res    = '0;
        o_res.last = i_last;

        if (i_mode == b64sc_pkg::MODE_ENCODE) begin
            if (enc_cnt == 3'd3 || i_last) begin
                o_emit          = 1'b1;
                o_res.last_idx  = 2'd3;
                o_res.bytes[0]  = b64sc_pkg::char_of(enc_bits[23:18]);
                o_res.bytes[1]  = b64sc_pkg::char_of(enc_bits[17:12]);
                o_res.bytes[2]  = (enc_cnt >= 3'd2) ? b64sc_pkg::char_of(enc_bits[11:6])
                                                    : b64sc_pkg::PAD_CHAR;
                o_res.bytes[3]  = (enc_cnt >= 3'd3) ? b64sc_pkg::char_of(enc_bits[5:0])
                                                    : b64sc_pkg::PAD_CHAR;
            end else begin
                o_group.bits  = enc_bits;
                o_group.count = enc_cnt[1:0];
            end
        end else begin
            if (dec_bad) begin
                // invalid character: single error word, group dropped
                o_emit    = 1'b1;
                o_res.bad = 1'b1;
            end else if (i_group.count == 2'd3) begin
                o_emit         = 1'b1;
                o_res.last_idx = 2'd2 - dec_pad;
                o_res.bytes[0] = dec_bits[23:16];
                o_res.bytes[1] = dec_bits[15:8];
                o_res.bytes[2] = dec_bits[7:0];
            end else if (i_last) begin
                // message ends inside a group
                o_emit    = 1'b1;
                o_res.bad = 1'b1;
            end else begin
                o_group.bits  = dec_bits;
                o_group.count = i_group.count + 2'd1;
                o_group.pad   = dec_pad;
            end
        end
    end

endmodule

// ----- hw/rtl/b64sc_out_ser.sv -----
// ----------------------------------------------------------------------------
// b64sc_out_ser
// result register that hands out the words of one group, one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module b64sc_out_ser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  b64sc_pkg::t_result i_res,
    output logic               o_free,
    b64sc_out_if.source        o_out
);

    logic               r_valid, n_valid;
    logic [1:0]         r_idx, n_idx;
    b64sc_pkg::t_result r_res, n_res;
    logic               take;
    logic               at_end;

    assign take   = r_valid && o_out.ready;
    assign at_end = (r_idx == r_res.last_idx);
    assign o_free = !r_valid || (take && at_end);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_res   = r_res;
        if (take) begin
            if (at_end) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
            n_res   = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_res.bytes[r_idx];
    assign o_out.out_last  = r_res.last && at_end;
    assign o_out.bad_input = r_res.bad;

endmodule

// ----- hw/rtl/base64_stream_codec_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// base64 stream encoder and decoder with a mode register and word channels
// ----------------------------------------------------------------------------
// output: the first result word of a group is valid in the cycle after the
//   word that completes the group (or fails) is taken
// throughput: one result word per cycle while the receiver is ready; a new
//   input word is taken whenever the result register is empty or hands out
//   its final word, so encode input is paced by the register's four-word drain
// reset: synchronous, active low; clears the mode to encode and the group state
//   and empties the result register
// ----------------------------------------------------------------------------
module base64_stream_codec_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    b64sc_in_if.sink    i_in,
    b64sc_out_if.source o_out
);

    // mode register and group being gathered
    logic              r_mode;
    b64sc_pkg::t_group r_group, n_group;

    // combinational fold of the incoming word
    b64sc_pkg::t_group  grp_next;
    logic               grp_emit;
    b64sc_pkg::t_result grp_res;

    logic ser_free;
    logic accept;

    // ready only tracks the result register, never the payload
    assign i_in.ready = ser_free;
    assign accept     = i_in.valid && ser_free;

    b64sc_group_logic u_group (
        .i_group (r_group),
        .i_mode  (r_mode),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .o_group (grp_next),
        .o_emit  (grp_emit),
        .o_res   (grp_res)
    );

    // group state moves on each accepted word; a mode write starts afresh
    always_comb begin
        n_group = r_group;
        if (i_cfg_wr_en) begin
            n_group = '0;
        end else if (accept) begin
            n_group = grp_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= b64sc_pkg::MODE_ENCODE;
            r_group <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_group <= n_group;
        end
    end

    // result register and word-by-word hand-out
    b64sc_out_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && grp_emit),
        .i_res   (grp_res),
        .o_free  (ser_free),
        .o_out   (o_out)
    );

endmodule

// ----- verif/tb_base64_stream_codec_top.sv -----
// ----------------------------------------------------------------------------
// tb_base64_stream_codec_top
// self-checking bench for the base64 stream codec: words are driven at random
// pace, each accepted word is run through a behavioural codec in the bench and
// every result word is compared in order with what that codec says is due
// ----------------------------------------------------------------------------
module tb_base64_stream_codec_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int IDLE_PCT     = 21;
    localparam int SETTLE_LEN   = 4;    // result register empties on the last take
    localparam int PHASE_WORDS  = 30;
    localparam int RANDOM_MODES = 6;

    // one result word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_word;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    b64sc_in_if  in_ch ();
    b64sc_out_if out_ch ();

    base64_stream_codec_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    always #1 clk = ~clk;

    // lookup tables between sextets and alphabet characters
    logic [7:0] sextet_char [64];
    logic [6:0] char_sextet [256];

    // codec state as the bench sees it
    logic        mode_decode;
    logic [23:0] grp_bits;
    logic [2:0]  grp_count;
    logic [1:0]  grp_pads;

    // result words still due from the block, oldest first
    t_word coded_words [$];

    int mismatches   = 0;
    int words_sent   = 0;
    int rx_hold_left = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;

    t_word due_word;

    function automatic void build_tables();
        for (int c = 0; c < 256; c++) begin
            char_sextet[c] = b64sc_pkg::SEXTET_BAD;
        end
        for (int v = 0; v < 64; v++) begin
            sextet_char[v] = B64_ALPHABET[v];
            char_sextet[B64_ALPHABET[v]] = 7'(v);
        end
        char_sextet[b64sc_pkg::PAD_CHAR] = b64sc_pkg::SEXTET_PAD;
    endfunction

    function automatic void clear_group();
        grp_bits  = '0;
        grp_count = '0;
        grp_pads  = '0;
    endfunction

    // works out the result words of one accepted input word
    function automatic void run_codec_step(input logic [7:0] b, input logic l);
        logic [6:0] sx;
        int         n;
        if (mode_decode == b64sc_pkg::MODE_ENCODE) begin
            grp_bits  = grp_bits | (24'(b) << (16 - 8 * grp_count));
            grp_count = grp_count + 3'd1;
            if (grp_count < 3'd3 && !l) begin
                return;
            end
            coded_words.push_back('{sextet_char[grp_bits[23:18]], 1'b0, 1'b0});
            coded_words.push_back('{sextet_char[grp_bits[17:12]], 1'b0, 1'b0});
            coded_words.push_back('{(grp_count >= 3'd2) ? sextet_char[grp_bits[11:6]]
                                                         : b64sc_pkg::PAD_CHAR, 1'b0, 1'b0});
            coded_words.push_back('{(grp_count >= 3'd3) ? sextet_char[grp_bits[5:0]]
                                                         : b64sc_pkg::PAD_CHAR, l, 1'b0});
            clear_group();
            return;
        end
        sx = char_sextet[b];
        // stray character, early pad or data after a pad
        if (sx == b64sc_pkg::SEXTET_BAD ||
            (sx == b64sc_pkg::SEXTET_PAD && grp_count < 3'd2) ||
            (sx != b64sc_pkg::SEXTET_PAD && grp_pads != 2'd0)) begin
            clear_group();
            coded_words.push_back('{8'd0, l, 1'b1});
            return;
        end
        if (sx == b64sc_pkg::SEXTET_PAD) begin
            grp_pads = grp_pads + 2'd1;
        end else begin
            grp_bits = grp_bits | (24'(sx[5:0]) << (18 - 6 * grp_count));
        end
        grp_count = grp_count + 3'd1;
        if (grp_count == 3'd4) begin
            n = 3 - grp_pads;
            for (int i = 0; i < n; i++) begin
                coded_words.push_back('{8'(grp_bits >> (16 - 8 * i)),
                                        (i + 1 == n) ? l : 1'b0, 1'b0});
            end
            clear_group();
        end else if (l) begin
            // message ends inside a group
            clear_group();
            coded_words.push_back('{8'd0, 1'b1, 1'b1});
        end
    endfunction

    // result word checker
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (coded_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%t: word with nothing due: byte %h last %b bad %b", $realtime,
                             out_ch.out_byte, out_ch.out_last, out_ch.bad_input);
                end
            end else begin
                due_word = coded_words.pop_front();
                if (out_ch.out_byte !== due_word.data || out_ch.out_last !== due_word.last ||
                    out_ch.bad_input !== due_word.bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t: byte %h last %b bad %b, wanted byte %h last %b bad %b",
                                 $realtime, out_ch.out_byte, out_ch.out_last,
                                 out_ch.bad_input, due_word.data, due_word.last,
                                 due_word.bad);
                    end
                end
            end
        end
    end

    // receiver: long hold-offs first, then random stalls unless switched off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_left > 0) begin
                out_ch.ready = 1'b0;
                rx_hold_left--;
            end else if (!rx_idle_on) begin
                out_ch.ready = 1'b1;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // offers one word, entered and left at a falling edge; valid stays high
    task automatic send_word(input logic [7:0] b, input logic l);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid   = 1'b0;
            in_ch.in_byte = 8'($urandom_range(0, 255));
            in_ch.in_last = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.in_last = l;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        run_codec_step(b, l);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic l);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], l && (i == s.len() - 1));
        end
    endtask

    // stop offering and let every due word come out
    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (coded_words.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_LEN) @(negedge clk);
    endtask

    // mode write, only ever issued with the block drained
    task automatic write_mode(input logic m);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(posedge clk);
        mode_decode = m;
        clear_group();
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_bytes_message();
        int len;
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // mostly well-formed text, now and then a stray, truncated or badly padded one
    task automatic send_text_message();
        logic [7:0] msg [$];
        int         groups;
        int         pads;
        int         kind;
        int         keep;
        groups = $urandom_range(1, 4);
        for (int i = 0; i < 4 * groups; i++) begin
            msg.push_back(sextet_char[$urandom_range(0, 63)]);
        end
        pads = $urandom_range(0, 2);
        if (pads >= 1) msg[msg.size() - 1] = b64sc_pkg::PAD_CHAR;
        if (pads == 2) msg[msg.size() - 2] = b64sc_pkg::PAD_CHAR;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind < 14) begin
            keep = $urandom_range(1, msg.size() - 1);
            while (msg.size() > keep) begin
                void'(msg.pop_back());
            end
        end else if (kind < 19) begin
            msg[$urandom_range(0, msg.size() - 1)] = b64sc_pkg::PAD_CHAR;
        end
        for (int i = 0; i < msg.size(); i++) begin
            send_word(msg[i], i == msg.size() - 1);
        end
    endtask

    // encoder on its reset mode, then full groups and both short flushes
    task automatic test_encode_corners();
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b0);
        write_mode(b64sc_pkg::MODE_ENCODE);
        send_word(8'h01, 1'b1);
        send_word(8'h7F, 1'b0);
        send_word(8'hFE, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // padding in and at the end of a stream, every kind of bad character
    task automatic test_decode_corners();
        write_mode(b64sc_pkg::MODE_DECODE);
        send_text("+/9a", 1'b0);
        send_text("TQ==", 1'b0);
        send_text("TWE=", 1'b1);
        send_text("0W=A", 1'b0);
        send_text("=", 1'b0);
        send_text("A=", 1'b0);
        send_text("Ab", 1'b1);
        send_text("*", 1'b1);
    endtask

    task automatic test_random_streams();
        int goal;
        for (int p = 0; p < RANDOM_MODES; p++) begin
            write_mode(p[0]);
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal) begin
                if (mode_decode == b64sc_pkg::MODE_DECODE) begin
                    send_text_message();
                end else begin
                    send_bytes_message();
                end
            end
        end
    endtask

    // receiver stops for a long while so that the input side backs up
    task automatic test_input_stall();
        int goal;
        write_mode(b64sc_pkg::MODE_ENCODE);
        rx_hold_left = 80;
        goal = words_sent + 30;
        while (words_sent < goal) begin
            send_bytes_message();
        end
        drain_results();
        write_mode(b64sc_pkg::MODE_DECODE);
        rx_hold_left = 60;
        goal = words_sent + 20;
        while (words_sent < goal) begin
            send_text_message();
        end
        drain_results();
    endtask

    // no idling on either side
    task automatic test_full_rate();
        int goal;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int p = 0; p < 2; p++) begin
            write_mode(p[0]);
            goal = words_sent + 20;
            while (words_sent < goal) begin
                if (mode_decode == b64sc_pkg::MODE_DECODE) begin
                    send_text_message();
                end else begin
                    send_bytes_message();
                end
            end
        end
        drain_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        mode_decode   = b64sc_pkg::MODE_ENCODE;
        clear_group();
        build_tables();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_encode_corners();
        test_decode_corners();
        test_random_streams();
        test_input_stall();
        test_full_rate();

        // anything still due after the settle time counts against the run
        drain_results();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && coded_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #400us;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/b64sc_pkg.sv
hw/rtl/b64sc_in_if.sv
hw/rtl/b64sc_out_if.sv
hw/rtl/b64sc_group_logic.sv
hw/rtl/b64sc_out_ser.sv
hw/rtl/base64_stream_codec_top.sv
verif/tb_base64_stream_codec_top.sv
